/* sv/scanline_line_follow_steer_assert.svh */
// Assertion macros for the scanline line-follow steering block.
// Included by the top level; no other dependencies.
`ifndef SCANLINE_LINE_FOLLOW_STEER_ASSERT_SVH
`define SCANLINE_LINE_FOLLOW_STEER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/slfs_pkg.sv */
// Shared constants, types and helpers for the scanline line-follow steering block.
// No dependencies.
package slfs_pkg;

    // Default geometry
    localparam int ROW_WIDTH_DEF    = 320;
    localparam int CENTER_WIDTH_DEF = 80;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 16;
    localparam int BASE_W  = 8;
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 13;
    localparam int SPEED_W = 9;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = SUM_W + GAIN_W;
    localparam int WIDE_W  = SUM_W + 2;

    // Saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int SPEED_LIM = 255;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MIN_COUNT = 2'd3;

    // Register reset values
    localparam logic [PIX_W-1:0]  THRESHOLD_RST  = 8'd120;
    localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd590;
    localparam logic [BASE_W-1:0] BASE_RST       = 8'd70;
    localparam logic [CNT_W-1:0]  CENTER_MIN_RST = 7'd44;

    // Row totals handed from the accumulator to the steering stage
    typedef struct packed {
        logic [SUM_W-1:0] right_sum;
        logic [SUM_W-1:0] left_sum;
        logic             on_line;
    } row_sum_t;

    // Clamp a wide signed speed to +/- SPEED_LIM
    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        if (v > WIDE_W'(SPEED_LIM))
            r = SPEED_W'(SPEED_LIM);
        else if (v < -WIDE_W'(SPEED_LIM))
            r = -SPEED_W'(SPEED_LIM);
        else
            r = v[SPEED_W-1:0];
        return r;
    endfunction

endpackage

/* sv/scanline_line_follow_steer.sv */
// Top level of the scanline line-follow steering block.
// Depends on slfs_pkg and scanline_line_follow_steer_assert.svh.

// Takes one pixel transaction per clock with no gaps needed: the band weighting,
// the bright compare and the accumulator update all finish in the cycle the
// pixel is accepted. A pixel with row_end set closes the row; its totals move
// into a row-summary register at that edge, and from there the steering
// stage (one 13x16 multiply, the floor/ceiling correction and the speed clamp)
// loads the result register whenever that register is empty or being drained,
// which raises result_valid; the result transaction completes when
// result_ready is also high. The summary register and the result register
// together decouple the sides: pixel_ready drops only when a finished result
// waits and another row summary is already queued behind it. Columns past
// ROW_WIDTH are ignored, column zero lies in no band, the accumulators
// saturate at 8191 and the centre count at 127. Configuration writes take
// effect on the next clock and are meant for idle periods only.
module scanline_line_follow_steer #(
    parameter int ROW_WIDTH    = slfs_pkg::ROW_WIDTH_DEF,
    parameter int CENTER_WIDTH = slfs_pkg::CENTER_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [slfs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [slfs_pkg::CFG_DATA_W-1:0]        cfg_data,
    // pixel stream
    input  logic                                   pixel_valid,
    output logic                                   pixel_ready,
    input  logic [slfs_pkg::PIX_W-1:0]             pixel,
    input  logic                                   row_end,
    // row results
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [slfs_pkg::SPEED_W-1:0]    left_speed,
    output logic signed [slfs_pkg::SPEED_W-1:0]    right_speed,
    output logic [slfs_pkg::SUM_W-1:0]             right_weight_sum,
    output logic [slfs_pkg::SUM_W-1:0]             left_weight_sum,
    output logic                                   on_line,
    output logic                                   turning_left
);
    import slfs_pkg::*;

    `include "scanline_line_follow_steer_assert.svh"

    // Band geometry. SIDE is the width of each outer band; column SIDE is
    // shared by the right band (weight zero) and the centre band.
    localparam int SIDE       = ROW_WIDTH / 2 - CENTER_WIDTH / 2;
    localparam int LEFT_START = SIDE + CENTER_WIDTH;
    localparam int LEFT_END   = LEFT_START + SIDE;
    localparam int COL_W      = $clog2(ROW_WIDTH + 2);

    localparam logic [COL_W-1:0] ROW_END_C    = COL_W'(ROW_WIDTH);
    localparam logic [COL_W-1:0] SIDE_C       = COL_W'(SIDE);
    localparam logic [COL_W-1:0] LEFT_START_C = COL_W'(LEFT_START);
    localparam logic [COL_W-1:0] LEFT_END_C   = COL_W'(LEFT_END);
    localparam logic [COL_W-1:0] COL_ONE      = COL_W'(1);
    localparam logic [PROD_W:0]  CEIL_BIAS    = (PROD_W+1)'((1 << FRAC_W) - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  threshold_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [BASE_W-1:0] base_reg;
    logic [CNT_W-1:0]  center_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            gain_reg       <= GAIN_RST;
            base_reg       <= BASE_RST;
            center_min_reg <= CENTER_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIXEL_THRESHOLD:  threshold_reg  <= cfg_data[PIX_W-1:0];
                CFG_STEER_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                CFG_BASE_SPEED:       base_reg       <= cfg_data[BASE_W-1:0];
                CFG_CENTER_MIN_COUNT: center_min_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic     summary_valid_reg;
    row_sum_t summary_reg;
    logic     out_valid_reg;
    logic     summary_advance;
    logic     pixel_accept;

    // The summary moves on when the result register is empty or being drained.
    assign summary_advance = !out_valid_reg || result_ready;
    assign pixel_ready     = !summary_valid_reg || summary_advance;
    assign pixel_accept    = pixel_valid && pixel_ready;

    // ------------------------------------------------------------------
    // Per-pixel accumulation
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg,    col_next;
    logic [SUM_W-1:0] right_reg,  right_next;
    logic [SUM_W-1:0] left_reg,   left_next;
    logic [CNT_W-1:0] center_reg, center_next;

    logic             bright;
    logic             in_row;
    logic             hit_right;
    logic             hit_center;
    logic             hit_left;
    logic [COL_W-1:0] right_weight;
    logic [COL_W-1:0] left_weight;
    logic [SUM_W:0]   right_total;
    logic [SUM_W:0]   left_total;
    logic [CNT_W:0]   center_total;
    logic [SUM_W-1:0] right_upd;
    logic [SUM_W-1:0] left_upd;
    logic [CNT_W-1:0] center_upd;
    logic [COL_W-1:0] col_upd;
    row_sum_t         summary_next;
    logic             summary_valid_next;

    always_comb
    begin
        bright     = pixel > threshold_reg;
        in_row     = col_reg < ROW_END_C;
        hit_right  = bright && in_row && (col_reg >= COL_ONE) && (col_reg <= SIDE_C);
        hit_center = bright && in_row && (col_reg >= SIDE_C) && (col_reg < LEFT_START_C);
        hit_left   = bright && in_row && (col_reg >= LEFT_START_C) && (col_reg < LEFT_END_C);

        right_weight = SIDE_C - col_reg;
        left_weight  = col_reg - LEFT_START_C;

        right_total  = {1'b0, right_reg} + (SUM_W+1)'(right_weight);
        left_total   = {1'b0, left_reg} + (SUM_W+1)'(left_weight);
        center_total = {1'b0, center_reg} + (CNT_W+1)'(1);

        // Saturate each running sum at its register width.
        right_upd  = right_reg;
        left_upd   = left_reg;
        center_upd = center_reg;
        if (hit_right)
            right_upd = right_total[SUM_W] ? SUM_MAX : right_total[SUM_W-1:0];
        if (hit_left)
            left_upd = left_total[SUM_W] ? SUM_MAX : left_total[SUM_W-1:0];
        if (hit_center)
            center_upd = center_total[CNT_W] ? CNT_MAX : center_total[CNT_W-1:0];
        col_upd = in_row ? col_reg + COL_ONE : col_reg;

        // Hold by default; advance on an accepted pixel, clear at row end.
        col_next    = col_reg;
        right_next  = right_reg;
        left_next   = left_reg;
        center_next = center_reg;
        if (pixel_accept)
        begin
            if (row_end)
            begin
                col_next    = '0;
                right_next  = '0;
                left_next   = '0;
                center_next = '0;
            end
            else
            begin
                col_next    = col_upd;
                right_next  = right_upd;
                left_next   = left_upd;
                center_next = center_upd;
            end
        end

        summary_next.right_sum = right_upd;
        summary_next.left_sum  = left_upd;
        summary_next.on_line   = center_upd > center_min_reg;

        summary_valid_next = summary_valid_reg;
        if (pixel_accept && row_end)
            summary_valid_next = 1'b1;
        else if (summary_advance)
            summary_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg           <= '0;
            right_reg         <= '0;
            left_reg          <= '0;
            center_reg        <= '0;
            summary_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg           <= col_next;
            right_reg         <= right_next;
            left_reg          <= left_next;
            center_reg        <= center_next;
            summary_valid_reg <= summary_valid_next;
        end
    end

    // Row totals need no reset; the valid flag guards them.
    always_ff @(posedge clk)
    begin
        if (pixel_accept && row_end)
            summary_reg <= summary_next;
    end

    // ------------------------------------------------------------------
    // Steering: pick the larger error, scale it, form the wheel speeds
    // ------------------------------------------------------------------
    logic                     turn_left;
    logic [SUM_W-1:0]         err;
    logic [PROD_W-1:0]        scaled;
    logic [PROD_W:0]          scaled_up;
    logic [SUM_W-1:0]         err_floor;
    logic [SUM_W:0]           err_ceil;
    logic signed [WIDE_W-1:0] speed_plus;
    logic signed [WIDE_W-1:0] speed_minus;
    logic signed [SPEED_W-1:0] plus_sat;
    logic signed [SPEED_W-1:0] minus_sat;

    always_comb
    begin
        // Ties go to the left error.
        turn_left = summary_reg.right_sum > summary_reg.left_sum;
        err       = turn_left ? summary_reg.right_sum : summary_reg.left_sum;
        scaled    = PROD_W'(err) * PROD_W'(gain_reg);
        scaled_up = {1'b0, scaled} + CEIL_BIAS;
        err_floor = scaled[PROD_W-1:FRAC_W];
        err_ceil  = scaled_up[PROD_W:FRAC_W];

        speed_plus  = $signed({{(WIDE_W-BASE_W){1'b0}}, base_reg})
                    + $signed({{(WIDE_W-SUM_W){1'b0}}, err_floor});
        speed_minus = $signed({{(WIDE_W-BASE_W){1'b0}}, base_reg})
                    - $signed({{(WIDE_W-SUM_W-1){1'b0}}, err_ceil});
        plus_sat    = clamp_speed(speed_plus);
        minus_sat   = clamp_speed(speed_minus);
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                      out_valid_next;
    logic signed [SPEED_W-1:0] left_speed_reg;
    logic signed [SPEED_W-1:0] right_speed_reg;
    logic [SUM_W-1:0]          right_sum_reg;
    logic [SUM_W-1:0]          left_sum_reg;
    logic                      on_line_reg;
    logic                      turning_left_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (summary_advance)
            out_valid_next = summary_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (summary_advance && summary_valid_reg)
        begin
            left_speed_reg   <= turn_left ? minus_sat : plus_sat;
            right_speed_reg  <= turn_left ? plus_sat : minus_sat;
            right_sum_reg    <= summary_reg.right_sum;
            left_sum_reg     <= summary_reg.left_sum;
            on_line_reg      <= summary_reg.on_line;
            turning_left_reg <= turn_left;
        end
    end

    assign result_valid     = out_valid_reg;
    assign left_speed       = left_speed_reg;
    assign right_speed      = right_speed_reg;
    assign right_weight_sum = right_sum_reg;
    assign left_weight_sum  = left_sum_reg;
    assign on_line          = on_line_reg;
    assign turning_left     = turning_left_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A queued summary behind a stalled result must block the pixel side.
    `SLFS_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, summary_valid_reg && out_valid_reg && !result_ready, !pixel_ready, "pixel accepted while both stages are full")
    // Closing a row clears the running state.
    `SLFS_ASSERT_NEXT(a_row_end_clears, clk, rst_n, pixel_accept && row_end, col_reg == '0 && right_reg == '0 && left_reg == '0 && center_reg == '0, "row state not cleared after row end")
    // The column counter stops at the row width.
    `SLFS_ASSERT_NOW(a_col_bound, clk, rst_n, 1'b1, col_reg <= ROW_END_C, "column count past row width")
    // The wheel on the turning side never runs faster than the other.
    `SLFS_ASSERT_NOW(a_speed_order, clk, rst_n, result_valid, (turning_left && right_speed >= left_speed) || (!turning_left && left_speed >= right_speed), "steering speeds out of order")

endmodule
